// ===== hw/rtl/obd_pkg.sv =====
// obd_pkg: shared types, codes and constants for the obd mode 01 response decoder
// no dependencies; used by obd_frame_tracker, obd_result_decode and the top level
`timescale 1ns / 1ps
`default_nettype none

package obd_pkg;

	localparam int MAX_FRAME = 64;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int PAYLOAD_N = 4;
	localparam int PC_W      = $clog2(PAYLOAD_N + 1);

	localparam logic [7:0] MODE_RESP = 8'h41;

	localparam logic [7:0] PID_RPM     = 8'h0C;
	localparam logic [7:0] PID_COOLANT = 8'h05;
	localparam logic [7:0] PID_STFT    = 8'h06;
	localparam logic [7:0] PID_LTFT    = 8'h07;
	localparam logic [7:0] PID_O2      = 8'h14;
	localparam logic [7:0] PID_WB_LO0  = 8'h24;
	localparam logic [7:0] PID_WB_HI0  = 8'h2B;
	localparam logic [7:0] PID_WB_LO1  = 8'h34;
	localparam logic [7:0] PID_WB_HI1  = 8'h3B;
	localparam logic [7:0] PID_CMD_LAM = 8'h44;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_NO_MATCH  = 3'd2;
	localparam logic [2:0] ST_UNKNOWN   = 3'd3;
	localparam logic [2:0] ST_LAM_FLOOR = 3'd4;

	localparam logic [2:0] Q_RPM     = 3'd0;
	localparam logic [2:0] Q_COOLANT = 3'd1;
	localparam logic [2:0] Q_STFT    = 3'd2;
	localparam logic [2:0] Q_LTFT    = 3'd3;
	localparam logic [2:0] Q_O2      = 3'd4;
	localparam logic [2:0] Q_WB_LAM  = 3'd5;
	localparam logic [2:0] Q_CMD_LAM = 3'd6;

	localparam logic [15:0] LAMBDA_FLOOR_RST = 16'd13108;
	localparam logic [7:0]  COOLANT_OFS      = 8'd40;
	localparam logic [16:0] TRIM_SCALE       = 17'd100;
	localparam logic [16:0] TRIM_OFS         = 17'd12800;
	localparam logic [24:0] AFR_SCALE        = 25'd147;

	// frame state as seen after the current beat
	typedef struct packed {
		logic            match;
		logic [CNT_W-1:0] byte_count;
		logic [PC_W-1:0]  payload_count;
		logic [7:0]       p0;
		logic [7:0]       p1;
	} frame_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [2:0]         quantity;
		logic signed [16:0] value_a;
		logic signed [24:0] value_b;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/obd_pid_response_decoder_top.sv =====
// obd_pid_response_decoder_top: input register, frame tracker, decode and result register
// depends on obd_pkg, obd_frame_tracker and obd_result_decode
//
// usage:
//   s_* takes one received response byte per beat: s_tdata is the byte, s_tuser the
//   requested pid, s_tlast marks the final byte of the frame. only the beat with
//   s_tlast high yields a result beat on m_*; other beats update the frame state.
//   m_tuser carries status and quantity, m_tdata the two fixed-point values.
//   cfg_* writes lambda_floor, the smallest raw lambda code taken as valid;
//   write it only while the block is idle. cfg_ready is always high.
//   path: a result beat passes through the input register, then the result register,
//   before it is presented on m_*; a result stall can hold its last byte in the input
//   register. throughput is one byte per cycle while no such stall holds the input
//   register, set by the single decode pass between the two registers.
//   reset: frame state clears, no result is pending, lambda_floor returns to 13108.
//   stall: while m_tready is low and a result waits, bytes that end no frame keep
//   flowing; a second last byte holds in the input register and s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module obd_pid_response_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	input  wire logic [7:0]  s_tuser,   // requested_pid
	input  wire logic        s_tlast,   // last_byte
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [47:0] m_tdata,   // value_a[16:0], value_b[41:17], zero pad
	output      logic [7:0]  m_tuser,   // status[2:0], quantity[5:3], zero pad
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [15:0] cfg_data   // lambda_floor
);

	logic [15:0] lambda_floor_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] pid_s1;
	logic       last_s1;

	logic              step;
	obd_pkg::frame_t   frame;
	obd_pkg::result_t  result;
	obd_pkg::result_t  out_q;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_floor_q <= obd_pkg::LAMBDA_FLOOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			lambda_floor_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			pid_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	obd_frame_tracker u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.pid     (pid_s1),
		.last    (last_s1),
		.frame   (frame)
	);

	obd_result_decode u_decode (
		.frame        (frame),
		.pid          (pid_s1),
		.lambda_floor (lambda_floor_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.value_b, out_q.value_a};
	assign m_tuser  = {2'd0, out_q.quantity, out_q.status};

endmodule

`default_nettype wire

// ===== hw/rtl/obd_frame_tracker.sv =====
// obd_frame_tracker: byte count, 0x41 + pid match search and payload capture
// depends on obd_pkg
`timescale 1ns / 1ps
`default_nettype none

module obd_frame_tracker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [7:0]    pid,
	input  wire logic          last,
	output obd_pkg::frame_t    frame
);

	logic [obd_pkg::CNT_W-1:0] byte_count_q;
	logic [7:0]                prev_q;
	logic                      match_q;
	logic [obd_pkg::PC_W-1:0]  payload_count_q;
	logic [7:0]                payload_q [obd_pkg::PAYLOAD_N];

	logic counted;
	logic wr_payload;
	logic hit;

	assign counted    = byte_count_q < obd_pkg::CNT_W'(obd_pkg::MAX_FRAME);
	assign wr_payload = counted && match_q &&
		(payload_count_q < obd_pkg::PC_W'(obd_pkg::PAYLOAD_N));
	assign hit        = counted && !match_q && (byte_count_q != '0) &&
		(prev_q == obd_pkg::MODE_RESP) && (rx_byte == pid);

	always_comb begin
		frame.match         = match_q || hit;
		frame.byte_count    = counted ? byte_count_q + 1'b1 : byte_count_q;
		frame.payload_count = wr_payload ? payload_count_q + 1'b1 : payload_count_q;
		frame.p0 = (wr_payload && payload_count_q == '0) ? rx_byte : payload_q[0];
		frame.p1 = (wr_payload && payload_count_q == obd_pkg::PC_W'(1)) ?
			rx_byte : payload_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			prev_q          <= '0;
			match_q         <= 1'b0;
			payload_count_q <= '0;
		end else if (step) begin
			if (last) begin
				byte_count_q    <= '0;
				prev_q          <= '0;
				match_q         <= 1'b0;
				payload_count_q <= '0;
			end else begin
				byte_count_q    <= frame.byte_count;
				match_q         <= frame.match;
				payload_count_q <= frame.payload_count;
				if (counted) begin
					prev_q <= rx_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_payload) begin
			payload_q[payload_count_q[1:0]] <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/obd_result_decode.sv =====
// obd_result_decode: turns the end-of-frame state into status and fixed-point values
// depends on obd_pkg
`timescale 1ns / 1ps
`default_nettype none

module obd_result_decode (
	input  wire obd_pkg::frame_t  frame,
	input  wire logic [7:0]       pid,
	input  wire logic [15:0]      lambda_floor,
	output obd_pkg::result_t      result
);

	logic [15:0]        ab;
	logic signed [16:0] trim_a;
	logic signed [16:0] trim_b;
	logic               is_wb;
	logic               n1;
	logic               n2;
	logic               n4;
	logic               lam_ok;

	assign ab     = {frame.p0, frame.p1};
	assign trim_a = $signed({9'd0, frame.p0} * obd_pkg::TRIM_SCALE - obd_pkg::TRIM_OFS);
	assign trim_b = $signed({9'd0, frame.p1} * obd_pkg::TRIM_SCALE - obd_pkg::TRIM_OFS);
	assign is_wb  = (pid >= obd_pkg::PID_WB_LO0 && pid <= obd_pkg::PID_WB_HI0) ||
		(pid >= obd_pkg::PID_WB_LO1 && pid <= obd_pkg::PID_WB_HI1);
	assign n1     = frame.payload_count >= obd_pkg::PC_W'(1);
	assign n2     = frame.payload_count >= obd_pkg::PC_W'(2);
	assign n4     = frame.payload_count >= obd_pkg::PC_W'(4);
	assign lam_ok = ab >= lambda_floor;

	always_comb begin
		result.status   = obd_pkg::ST_OK;
		result.quantity = obd_pkg::Q_RPM;
		result.value_a  = '0;
		result.value_b  = '0;
		if (frame.byte_count < obd_pkg::CNT_W'(4)) begin
			result.status = obd_pkg::ST_SHORT;
		end else if (!frame.match || !n1) begin
			result.status = obd_pkg::ST_NO_MATCH;
		end else if (pid == obd_pkg::PID_RPM && n2) begin
			result.value_a = $signed({1'b0, ab});
		end else if (pid == obd_pkg::PID_COOLANT) begin
			result.quantity = obd_pkg::Q_COOLANT;
			result.value_a  = $signed({9'd0, frame.p0} - {9'd0, obd_pkg::COOLANT_OFS});
		end else if (pid == obd_pkg::PID_STFT) begin
			result.quantity = obd_pkg::Q_STFT;
			result.value_a  = trim_a;
		end else if (pid == obd_pkg::PID_LTFT) begin
			result.quantity = obd_pkg::Q_LTFT;
			result.value_a  = trim_a;
		end else if (pid == obd_pkg::PID_O2 && n2) begin
			result.quantity = obd_pkg::Q_O2;
			result.value_a  = $signed({9'd0, frame.p0});
			result.value_b  = 25'(trim_b);
		end else if (is_wb && n4) begin
			result.quantity = obd_pkg::Q_WB_LAM;
			result.value_a  = $signed({1'b0, ab});
			if (lam_ok) begin
				result.value_b = $signed({9'd0, ab} * obd_pkg::AFR_SCALE);
			end else begin
				result.status = obd_pkg::ST_LAM_FLOOR;
			end
		end else if (pid == obd_pkg::PID_CMD_LAM && n2) begin
			result.quantity = obd_pkg::Q_CMD_LAM;
			result.value_a  = $signed({1'b0, ab});
			result.status   = lam_ok ? obd_pkg::ST_OK : obd_pkg::ST_LAM_FLOOR;
		end else begin
			result.status = obd_pkg::ST_UNKNOWN;
		end
	end

endmodule

`default_nettype wire

// ===== bench/obd_reading_checker.sv =====
// obd_reading_checker: watches the byte, result and lambda_floor channels of the decoder,
// predicts each decoded reading and compares it field by field with the result beats
// depends on obd_pkg for field types, status and quantity codes and pid constants
`timescale 1ns / 1ps

module obd_reading_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	input  wire logic [7:0]  s_tuser,   // requested_pid
	input  wire logic        s_tlast,   // last_byte
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,   // value_a[16:0], value_b[41:17], zero pad
	input  wire logic [7:0]  m_tuser,   // status[2:0], quantity[5:3], zero pad
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [15:0] cfg_data,  // lambda_floor
	output int               fail_count,
	output int               pending
);
	import obd_pkg::*;

	logic [6:0]  frame_len;
	logic [7:0]  prev_rx;
	logic        pair_seen;
	logic [2:0]  payload_len;
	logic [7:0]  payload [4];
	logic [15:0] floor_code;
	result_t     expected_readings [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic void clear_frame();
		frame_len = '0;
		prev_rx = '0;
		pair_seen = 1'b0;
		payload_len = '0;
		for (int i = 0; i < 4; i++)
			payload[i] = '0;
	endfunction

	function automatic result_t decode_reading(input logic [7:0] pid);
		result_t r;
		int a0;
		int a1;
		int ab;
		int tmp;
		logic wideband;
		a0 = payload[0];
		a1 = payload[1];
		ab = a0 * 256 + a1;
		wideband = (pid >= PID_WB_LO0 && pid <= PID_WB_HI0) ||
			(pid >= PID_WB_LO1 && pid <= PID_WB_HI1);
		r = '0;
		if (pid == PID_RPM && payload_len >= 2) begin
			r.quantity = Q_RPM;
			r.value_a = ab[16:0];
		end else if (pid == PID_COOLANT && payload_len >= 1) begin
			tmp = a0 - int'(COOLANT_OFS);
			r.quantity = Q_COOLANT;
			r.value_a = tmp[16:0];
		end else if ((pid == PID_STFT || pid == PID_LTFT) && payload_len >= 1) begin
			tmp = int'(TRIM_SCALE) * a0 - int'(TRIM_OFS);
			r.quantity = (pid == PID_STFT) ? Q_STFT : Q_LTFT;
			r.value_a = tmp[16:0];
		end else if (pid == PID_O2 && payload_len >= 2) begin
			tmp = int'(TRIM_SCALE) * a1 - int'(TRIM_OFS);
			r.quantity = Q_O2;
			r.value_a = a0[16:0];
			r.value_b = tmp[24:0];
		end else if (wideband && payload_len >= 4) begin
			r.quantity = Q_WB_LAM;
			r.value_a = ab[16:0];
			if (ab >= int'(floor_code)) begin
				tmp = ab * int'(AFR_SCALE);
				r.value_b = tmp[24:0];
			end else begin
				r.status = ST_LAM_FLOOR;
			end
		end else if (pid == PID_CMD_LAM && payload_len >= 2) begin
			r.quantity = Q_CMD_LAM;
			r.value_a = ab[16:0];
			r.status = (ab >= int'(floor_code)) ? ST_OK : ST_LAM_FLOOR;
		end else begin
			r.status = ST_UNKNOWN;
		end
		return r;
	endfunction

	task automatic take_byte(input logic [7:0] rx, input logic [7:0] pid, input logic last);
		result_t r;
		if (frame_len < MAX_FRAME) begin
			if (pair_seen) begin
				if (payload_len < 4) begin
					payload[payload_len[1:0]] = rx;
					payload_len++;
				end
			end else if (frame_len >= 1 && prev_rx == MODE_RESP && rx == pid) begin
				pair_seen = 1'b1;
			end
			prev_rx = rx;
			frame_len++;
		end
		if (last) begin
			r = '0;
			if (frame_len < 4)
				r.status = ST_SHORT;
			else if (!pair_seen || payload_len == 0)
				r.status = ST_NO_MATCH;
			else
				r = decode_reading(pid);
			expected_readings.push_back(r);
			clear_frame();
		end
	endtask

	task automatic check_reading();
		result_t want;
		logic [2:0] got_status;
		logic [2:0] got_quantity;
		logic [16:0] got_a;
		logic [24:0] got_b;
		got_status = m_tuser[2:0];
		got_quantity = m_tuser[5:3];
		got_a = m_tdata[16:0];
		got_b = m_tdata[41:17];
		if (expected_readings.size() == 0) begin
			report_mismatch($sformatf("result beat with no reading pending (status %0d)",
				got_status));
		end else begin
			want = expected_readings.pop_front();
			if (got_status != want.status)
				report_mismatch($sformatf("status got %0d want %0d",
					got_status, want.status));
			if (got_quantity != want.quantity)
				report_mismatch($sformatf("quantity got %0d want %0d",
					got_quantity, want.quantity));
			if (got_a != want.value_a)
				report_mismatch($sformatf("value_a got %0d want %0d",
					$signed(got_a), want.value_a));
			if (got_b != want.value_b)
				report_mismatch($sformatf("value_b got %0d want %0d",
					$signed(got_b), want.value_b));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			floor_code = LAMBDA_FLOOR_RST;
			expected_readings.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				floor_code = cfg_data;
			if (m_tvalid && m_tready)
				check_reading();
			if (s_tvalid && s_tready)
				take_byte(s_tdata, s_tuser, s_tlast);
		end
		pending = expected_readings.size();
	end

endmodule

// ===== bench/testbench.sv =====
// testbench: drives response frames and lambda_floor writes into obd_pid_response_decoder_top
// with bursty input, a stalling result side and long hold-offs; verdict from the checker
// depends on obd_pkg, obd_pid_response_decoder_top and obd_reading_checker
`timescale 1ns / 1ps

module testbench;
	import obd_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BEATS = 230;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [7:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending;

	logic [7:0]  frame_bytes [$];
	logic [15:0] floor_now = LAMBDA_FLOOR_RST;
	int          beats_sent = 0;
	int          burst_left = 0;
	int          hold_asks = 0;
	int          holds_served = 0;
	int          hold_left = 0;
	int          rx_mode = 0;
	int          rx_mode_left = 0;
	int          rx_phase = 0;
	int          idle_cycles = 0;

	obd_pid_response_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	obd_reading_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// result side: random stall patterns, plus long hold-offs on request
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (holds_served != hold_asks) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_mode_left <= $urandom_range(20, 150);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 4) == 0);
				default: m_tready <= ((rx_phase % 8) < 5);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge where the beat was taken
	task automatic send_beat(input logic [7:0] rx, input logic [7:0] pid, input logic last);
		int gap;
		logic taken;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		s_tuser <= pid;
		s_tlast <= last;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		burst_left--;
		beats_sent++;
	endtask

	task automatic send_frame(input logic [7:0] pid);
		for (int i = 0; i < frame_bytes.size(); i++)
			send_beat(frame_bytes[i], pid, i == frame_bytes.size() - 1);
		frame_bytes.delete();
	endtask

	// let the checker queue the last beat before pending is read
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_floor(input logic [15:0] code);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		floor_now = code;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return MODE_RESP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_pid();
		case ($urandom_range(0, 9))
			0: return PID_RPM;
			1: return PID_COOLANT;
			2: return PID_STFT;
			3: return PID_LTFT;
			4: return PID_O2;
			5: return PID_WB_LO0 + 8'($urandom_range(0, 7));
			6: return PID_WB_LO1 + 8'($urandom_range(0, 7));
			7: return PID_CMD_LAM;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_frame();
		int kind;
		int n;
		int len;
		int pos;
		logic [7:0] pid;
		logic lambda_pid;
		kind = $urandom_range(0, 99);
		pid = pick_pid();
		if (kind < 70) begin
			lambda_pid = (pid >= PID_WB_LO0 && pid <= PID_WB_HI0) ||
				(pid >= PID_WB_LO1 && pid <= PID_WB_HI1) || pid == PID_CMD_LAM;
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4;
			repeat ($urandom_range(0, 2)) frame_bytes.push_back(pick_byte());
			frame_bytes.push_back(MODE_RESP);
			frame_bytes.push_back(pid);
			for (int i = 0; i < n; i++) begin
				if (i == 0 && lambda_pid && $urandom_range(0, 1))
					frame_bytes.push_back(floor_now[15:8] + 8'($urandom_range(0, 2)) - 8'd1);
				else
					frame_bytes.push_back(pick_byte());
			end
			repeat ($urandom_range(0, 1)) frame_bytes.push_back(pick_byte());
		end else if (kind < 85) begin
			pid = 8'($urandom_range(0, 255));
			repeat ($urandom_range(1, 8)) frame_bytes.push_back(pick_byte());
		end else if (kind < 97) begin
			case ($urandom_range(0, 2))
				0: begin
					repeat ($urandom_range(0, 2)) frame_bytes.push_back(pick_byte());
					frame_bytes.push_back(MODE_RESP);
					frame_bytes.push_back(pid);
				end
				1: begin
					frame_bytes.push_back(MODE_RESP);
					frame_bytes.push_back(pid ^ 8'h01);
					repeat ($urandom_range(0, 3)) frame_bytes.push_back(pick_byte());
				end
				default: repeat ($urandom_range(1, 3)) frame_bytes.push_back(pick_byte());
			endcase
		end else begin
			// overlong frame, the pair may land near or past the counted window
			len = $urandom_range(65, 72);
			pos = $urandom_range(0, len - 2);
			for (int i = 0; i < len; i++) begin
				if (i == pos)
					frame_bytes.push_back(MODE_RESP);
				else if (i == pos + 1)
					frame_bytes.push_back(pid);
				else
					frame_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		send_frame(pid);
	endtask

	initial begin
		int phase_start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_bytes = '{MODE_RESP, PID_RPM, 8'hFF, 8'hFF};
		send_frame(PID_RPM);
		frame_bytes = '{MODE_RESP, PID_COOLANT, 8'h00, 8'h7F};
		send_frame(PID_COOLANT);
		frame_bytes = '{MODE_RESP, PID_O2, 8'hFF, 8'h00};
		send_frame(PID_O2);
		// wideband just under the reset floor
		frame_bytes = '{MODE_RESP, PID_WB_HI1, 8'h33, 8'h33, 8'h00, 8'h00};
		send_frame(PID_WB_HI1);
		frame_bytes = '{MODE_RESP, PID_CMD_LAM, 8'hFF, 8'hFF};
		send_frame(PID_CMD_LAM);
		frame_bytes = '{MODE_RESP};
		send_frame(PID_RPM);
		frame_bytes = '{MODE_RESP, 8'h00, 8'h12, 8'h34};
		send_frame(8'h00);
		settle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: write_floor(16'h0000);
				2: write_floor(16'hFFFF);
				3: write_floor(16'($urandom_range(0, 65535)));
				4: write_floor(16'($urandom_range(16'h3000, 16'h3800)));
				default: ;
			endcase
			if (phase == 1 || phase == 3)
				hold_asks++;
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS)
				random_frame();
			settle();
		end

		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
